// ===== rtl/srdp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants of the radial deadzone / polar block.
// Holds the CORDIC arctangent table; no dependencies.
package srdp_pkg;

   localparam int RADIUS_W = 7;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 7'd60;

   localparam int SQRT_STEPS = 16;
   localparam int DIV_STEPS = 17;
   localparam int STEP_COUNT = SQRT_STEPS + 1 + DIV_STEPS;
   localparam int ATAN_LEN = 24;

   localparam int CW = 28;
   localparam int ZW = 35;

   localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;
   localparam logic [14:0] ANGLE_LIMIT = 15'd25736;
   localparam logic [15:0] MAG_LIMIT = 16'd32768;
   localparam logic [16:0] MAG_LIMIT_Q = 17'd32768;
   localparam logic [7:0] FULL_SCALE = 8'd128;
   localparam logic [ZW-1:0] ROUND_HALF = 35'd65536;

   typedef struct packed {
      logic [7:0] x_raw;
      logic [7:0] y_raw;
   } req_type;

   typedef struct packed {
      logic [15:0] magnitude;
      logic signed [15:0] angle;
      logic in_deadzone;
   } rsp_type;

   typedef struct packed {
      logic in_dz;
      logic zero;
      logic [RADIUS_W-1:0] r;
      logic [17:0] sq_rem;
      logic [15:0] sq_root;
      logic [31:0] sq_bits;
      logic [7:0] div_rem;
      logic [16:0] div_bits;
      logic [16:0] quot;
      logic [7:0] dvsr;
      logic ovf;
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic signed [ZW-1:0] cz;
   } stage_type;

   function automatic logic signed [ZW-1:0] atan_q30(input int idx);
      logic signed [ZW-1:0] val;
      unique case (idx)
         0: val = 35'sh03243F6A8;
         1: val = 35'sh01DAC6705;
         2: val = 35'sh00FADBAFC;
         3: val = 35'sh007F56EA6;
         4: val = 35'sh003FEAB76;
         5: val = 35'sh001FFD55B;
         6: val = 35'sh000FFFAAA;
         7: val = 35'sh0007FFF55;
         8: val = 35'sh0003FFFEA;
         9: val = 35'sh0001FFFFD;
         10: val = 35'sh0000FFFFF;
         11: val = 35'sh00007FFFF;
         12: val = 35'sh00003FFFF;
         13: val = 35'sh00001FFFF;
         14: val = 35'sh00000FFFF;
         15: val = 35'sh000007FFF;
         16: val = 35'sh000003FFF;
         17: val = 35'sh000001FFF;
         18: val = 35'sh000000FFF;
         19: val = 35'sh0000007FF;
         20: val = 35'sh0000003FF;
         21: val = 35'sh0000001FF;
         22: val = 35'sh0000000FF;
         23: val = 35'sh00000007F;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/srdp_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for stick samples and polar results.
// Depends on srdp_pkg for the payload types.
interface srdp_req_if;
   logic valid;
   logic ready;
   srdp_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface srdp_rsp_if;
   logic valid;
   logic ready;
   srdp_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/stick_radial_deadzone_polar.sv =====
`timescale 1ns / 1ps
// Radial deadzone and polar conversion of one analog stick sample per item.
// Pipeline: front stages, the 34-stage root/divide/CORDIC digit chain, then finish stages.
// Throughput: one item per cycle while the skid register is empty.
// A skid register holds a result the sink refuses; input stalls while it is full.
// Reset (synchronous) empties the pipeline and sets the deadzone radius to 60.
module stick_radial_deadzone_polar #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   srdp_req_if.sink                      req_if,
   srdp_rsp_if.source                    rsp_if,
   input  logic                          csr_we,
   input  logic [srdp_pkg::RADIUS_W-1:0] csr_wdata
);

   localparam int CORDIC_USED =
      (CORDIC_STAGES < srdp_pkg::ATAN_LEN) ? CORDIC_STAGES : srdp_pkg::ATAN_LEN;

   logic [srdp_pkg::RADIUS_W-1:0] radius_ff;
   logic en;
   logic step_valid [0:srdp_pkg::STEP_COUNT];
   srdp_pkg::stage_type step_stage [0:srdp_pkg::STEP_COUNT];
   logic tail_v;
   srdp_pkg::rsp_type tail_data;
   logic skid_v_ff, skid_v_in;
   srdp_pkg::rsp_type skid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= srdp_pkg::RADIUS_RESET;
      end else if (csr_we) begin
         radius_ff <= csr_wdata;
      end
   end

   assign en = !skid_v_ff;
   assign req_if.ready = en;

   srdp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_if.valid),
      .in_data   (req_if.data),
      .radius    (radius_ff),
      .out_valid (step_valid[0]),
      .out_stage (step_stage[0])
   );

   generate
      for (genvar k = 0; k < srdp_pkg::STEP_COUNT; k++) begin : g_step
         srdp_step #(
            .K           (k),
            .CORDIC_USED (CORDIC_USED)
         ) u_step (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .in_valid  (step_valid[k]),
            .in_stage  (step_stage[k]),
            .out_valid (step_valid[k+1]),
            .out_stage (step_stage[k+1])
         );
      end
   endgenerate

   srdp_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (step_valid[srdp_pkg::STEP_COUNT]),
      .in_stage  (step_stage[srdp_pkg::STEP_COUNT]),
      .out_valid (tail_v),
      .out_data  (tail_data)
   );

   always_comb begin
      priority if (skid_v_ff) begin
         skid_v_in = !rsp_if.ready;
      end else begin
         skid_v_in = tail_v && !rsp_if.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else begin
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_v_ff) begin
         skid_ff <= tail_data;
      end
   end

   assign rsp_if.valid = skid_v_ff || tail_v;
   assign rsp_if.data = skid_v_ff ? skid_ff : tail_data;

   a_dz_zeroed: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.data.in_deadzone |->
         rsp_if.data.magnitude == 16'd0 && rsp_if.data.angle == 16'sd0)
      else $error("deadzone item with nonzero outputs");

   a_mag_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.data.magnitude <= srdp_pkg::MAG_LIMIT)
      else $error("magnitude above saturation limit");

   a_angle_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |->
         rsp_if.data.angle >= -16'sd25736 && rsp_if.data.angle <= 16'sd25736)
      else $error("angle outside clamp range");

   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff && !rsp_if.ready |=> skid_v_ff && $stable(skid_ff))
      else $error("held item lost from skid register");

   a_skid_catch: assert property (@(posedge clock) disable iff (reset)
      !skid_v_ff && tail_v && !rsp_if.ready |=> skid_v_ff)
      else $error("refused item not captured");

endmodule

// ===== rtl/srdp_front.sv =====
`timescale 1ns / 1ps
// Front end: centering, squares, deadzone test and CORDIC pre-rotation.
// Three register stages; depends on srdp_pkg.
module srdp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  srdp_pkg::req_type             in_data,
   input  logic [srdp_pkg::RADIUS_W-1:0] radius,
   output logic                          out_valid,
   output srdp_pkg::stage_type           out_stage
);

   logic v0_ff, v1_ff, v2_ff;
   logic signed [8:0] x0_ff, x0_in, y0_ff, y0_in;
   logic [srdp_pkg::RADIUS_W-1:0] r0_ff, r1_ff;

   logic signed [17:0] xsq, ysq;
   logic signed [8:0] abs_x, yrot;
   logic xneg;
   logic [14:0] xx1_ff, yy1_ff;
   logic [13:0] rr1_ff, rr1_in;
   logic zero1_ff;
   logic signed [srdp_pkg::CW-1:0] cx1_ff, cx1_in, cy1_ff, cy1_in;
   logic signed [srdp_pkg::ZW-1:0] cz1_ff, cz1_in;

   logic [15:0] d2;
   srdp_pkg::stage_type stage_ff, stage_in;

   assign x0_in = $signed({1'b0, in_data.x_raw}) - 9'sd128;
   assign y0_in = 9'sd128 - $signed({1'b0, in_data.y_raw});

   assign xsq = x0_ff * x0_ff;
   assign ysq = y0_ff * y0_ff;
   assign rr1_in = 14'(r0_ff) * 14'(r0_ff);
   assign xneg = x0_ff[8];
   assign abs_x = xneg ? -x0_ff : x0_ff;
   assign yrot = xneg ? -y0_ff : y0_ff;

   always_comb begin
      cx1_in = {3'b000, abs_x, 16'h0000};
      cy1_in = {{3{yrot[8]}}, yrot, 16'h0000};
      if (!xneg) begin
         cz1_in = '0;
      end else if (y0_ff[8]) begin
         cz1_in = -srdp_pkg::PI_Q30;
      end else begin
         cz1_in = srdp_pkg::PI_Q30;
      end
   end

   assign d2 = {1'b0, xx1_ff} + {1'b0, yy1_ff};

   always_comb begin
      stage_in = '0;
      stage_in.in_dz = d2 < {2'b00, rr1_ff};
      stage_in.zero = zero1_ff;
      stage_in.r = r1_ff;
      stage_in.sq_bits = {d2, 16'h0000};
      stage_in.cx = cx1_ff;
      stage_in.cy = cy1_ff;
      stage_in.cz = cz1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff <= x0_in;
         y0_ff <= y0_in;
         r0_ff <= radius;
         xx1_ff <= xsq[14:0];
         yy1_ff <= ysq[14:0];
         rr1_ff <= rr1_in;
         r1_ff <= r0_ff;
         zero1_ff <= (x0_ff == 9'sd0) && (y0_ff == 9'sd0);
         cx1_ff <= cx1_in;
         cy1_ff <= cy1_in;
         cz1_ff <= cz1_in;
         stage_ff <= stage_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_stage = stage_ff;

endmodule

// ===== rtl/srdp_step.sv =====
`timescale 1ns / 1ps
// One pipeline stage: a square-root digit, a divider setup or quotient bit, and in the
// first CORDIC_USED stages a CORDIC vectoring rotation, chosen by stage index. Depends on srdp_pkg.
module srdp_step #(
   parameter int K = 0,
   parameter int CORDIC_USED = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  srdp_pkg::stage_type in_stage,
   output logic                out_valid,
   output srdp_pkg::stage_type out_stage
);

   logic valid_ff;
   srdp_pkg::stage_type stage_ff, stage_in;

   logic [17:0] sq_rem_n;
   logic [15:0] sq_root_n;
   logic [31:0] sq_bits_n;
   logic [7:0] div_rem_n;
   logic [16:0] div_bits_n;
   logic [16:0] quot_n;
   logic [7:0] dvsr_n;
   logic ovf_n;
   logic signed [srdp_pkg::CW-1:0] cx_n, cy_n;
   logic signed [srdp_pkg::ZW-1:0] cz_n;

   generate
      if (K < srdp_pkg::SQRT_STEPS) begin : g_sqrt
         always_comb begin
            logic [19:0] t;
            logic [19:0] trial;
            logic [19:0] diff;
            logic ge;
            t = {in_stage.sq_rem, in_stage.sq_bits[31:30]};
            trial = {2'b00, in_stage.sq_root, 2'b01};
            diff = t - trial;
            ge = t >= trial;
            sq_rem_n = ge ? diff[17:0] : t[17:0];
            sq_root_n = {in_stage.sq_root[14:0], ge};
            sq_bits_n = {in_stage.sq_bits[29:0], 2'b00};
         end
      end else begin : g_sqrt_hold
         assign sq_rem_n = in_stage.sq_rem;
         assign sq_root_n = in_stage.sq_root;
         assign sq_bits_n = in_stage.sq_bits;
      end
   endgenerate

   generate
      if (K == srdp_pkg::SQRT_STEPS) begin : g_div_setup
         always_comb begin
            logic [15:0] base;
            logic [15:0] diff;
            logic [22:0] num;
            base = {1'b0, in_stage.r, 8'h00};
            diff = (in_stage.sq_root >= base) ? in_stage.sq_root - base : 16'h0000;
            num = {diff, 7'b0000000};
            dvsr_n = srdp_pkg::FULL_SCALE - {1'b0, in_stage.r};
            ovf_n = {2'b00, diff} >= {dvsr_n, 10'b0000000000};
            div_rem_n = {2'b00, num[22:17]};
            div_bits_n = num[16:0];
            quot_n = '0;
         end
      end else if (K > srdp_pkg::SQRT_STEPS) begin : g_div_step
         always_comb begin
            logic [8:0] t;
            logic [8:0] diff;
            logic ge;
            t = {in_stage.div_rem, in_stage.div_bits[16]};
            diff = t - {1'b0, in_stage.dvsr};
            ge = t >= {1'b0, in_stage.dvsr};
            div_rem_n = ge ? diff[7:0] : t[7:0];
            div_bits_n = {in_stage.div_bits[15:0], 1'b0};
            quot_n = {in_stage.quot[15:0], ge};
            dvsr_n = in_stage.dvsr;
            ovf_n = in_stage.ovf;
         end
      end else begin : g_div_hold
         assign div_rem_n = in_stage.div_rem;
         assign div_bits_n = in_stage.div_bits;
         assign quot_n = in_stage.quot;
         assign dvsr_n = in_stage.dvsr;
         assign ovf_n = in_stage.ovf;
      end
   endgenerate

   generate
      if (K < CORDIC_USED) begin : g_cordic
         localparam logic signed [srdp_pkg::ZW-1:0] ATAN_K = srdp_pkg::atan_q30(K);
         always_comb begin
            logic signed [srdp_pkg::CW-1:0] x_c;
            logic signed [srdp_pkg::CW-1:0] y_c;
            logic signed [srdp_pkg::CW-1:0] dx;
            logic signed [srdp_pkg::CW-1:0] dy;
            x_c = in_stage.cx;
            y_c = in_stage.cy;
            dx = y_c >>> K;
            dy = x_c >>> K;
            if (!y_c[srdp_pkg::CW-1]) begin
               cx_n = x_c + dx;
               cy_n = y_c - dy;
               cz_n = in_stage.cz + ATAN_K;
            end else begin
               cx_n = x_c - dx;
               cy_n = y_c + dy;
               cz_n = in_stage.cz - ATAN_K;
            end
         end
      end else begin : g_cordic_hold
         assign cx_n = in_stage.cx;
         assign cy_n = in_stage.cy;
         assign cz_n = in_stage.cz;
      end
   endgenerate

   always_comb begin
      stage_in = in_stage;
      stage_in.sq_rem = sq_rem_n;
      stage_in.sq_root = sq_root_n;
      stage_in.sq_bits = sq_bits_n;
      stage_in.div_rem = div_rem_n;
      stage_in.div_bits = div_bits_n;
      stage_in.quot = quot_n;
      stage_in.dvsr = dvsr_n;
      stage_in.ovf = ovf_n;
      stage_in.cx = cx_n;
      stage_in.cy = cy_n;
      stage_in.cz = cz_n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ===== rtl/srdp_finish.sv =====
`timescale 1ns / 1ps
// Output stages: angle rounding and clamp, magnitude saturation, deadzone
// and centre zeroing. Two register stages; depends on srdp_pkg.
module srdp_finish (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  srdp_pkg::stage_type in_stage,
   output logic                out_valid,
   output srdp_pkg::rsp_type   out_data
);

   typedef struct packed {
      logic [15:0] mag;
      logic [17:0] q;
      logic neg;
      logic zero;
      logic in_dz;
   } fin_type;

   logic f1_valid_ff, f2_valid_ff;
   fin_type f1_ff, f1_in;
   srdp_pkg::rsp_type f2_ff, f2_in;

   always_comb begin
      logic [srdp_pkg::ZW-1:0] m;
      logic [srdp_pkg::ZW-1:0] rnd;
      m = in_stage.cz[srdp_pkg::ZW-1] ? -in_stage.cz : in_stage.cz;
      rnd = m + srdp_pkg::ROUND_HALF;
      f1_in.q = rnd[34:17];
      f1_in.neg = in_stage.cz[srdp_pkg::ZW-1];
      f1_in.zero = in_stage.zero;
      f1_in.in_dz = in_stage.in_dz;
      if (in_stage.ovf || (in_stage.quot > srdp_pkg::MAG_LIMIT_Q)) begin
         f1_in.mag = srdp_pkg::MAG_LIMIT;
      end else begin
         f1_in.mag = in_stage.quot[15:0];
      end
   end

   always_comb begin
      logic [14:0] qc;
      logic signed [15:0] ang;
      qc = (f1_ff.q > {3'b000, srdp_pkg::ANGLE_LIMIT}) ? srdp_pkg::ANGLE_LIMIT
                                                         : f1_ff.q[14:0];
      ang = f1_ff.neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
      priority if (f1_ff.in_dz) begin
         f2_in.magnitude = '0;
         f2_in.angle = '0;
         f2_in.in_deadzone = 1'b1;
      end else if (f1_ff.zero) begin
         f2_in.magnitude = f1_ff.mag;
         f2_in.angle = '0;
         f2_in.in_deadzone = 1'b0;
      end else begin
         f2_in.magnitude = f1_ff.mag;
         f2_in.angle = ang;
         f2_in.in_deadzone = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= in_valid;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_ff <= f1_in;
         f2_ff <= f2_in;
      end
   end

   assign out_valid = f2_valid_ff;
   assign out_data = f2_ff;

endmodule

// ===== test/tb_stick_radial_deadzone_polar.sv =====
`timescale 1ns / 1ps
// Testbench for stick_radial_deadzone_polar: directed samples, then random phases per radius.
// Results are checked against a fixed-point deadzone/CORDIC predictor, or for typed rows against the table.
// Depends on srdp_pkg and the srdp_req_if / srdp_rsp_if interfaces.
module tb_stick_radial_deadzone_polar;

   localparam int STAGE_COUNT_CFG = 16;
   localparam longint PI_ANGLE = 64'sd3373259426;
   localparam longint ATAN_Q30 [24] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6,
      'h03FEAB76, 'h01FFD55B, 'h00FFFAAA, 'h007FFF55,
      'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
      'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF,
      'h00003FFF, 'h00001FFF, 'h00000FFF, 'h000007FF,
      'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F
   };

   typedef struct packed {
      logic [srdp_pkg::RADIUS_W-1:0] radius;
      logic [7:0] x_raw;
      logic [7:0] y_raw;
      logic typed_in;
      logic [15:0] magnitude;
      logic [15:0] angle;
      logic in_deadzone;
   } sample_row_type;

   localparam int ROW_COUNT = 22;
   localparam sample_row_type SAMPLE_ROWS [ROW_COUNT] = '{
      '{7'd60, 8'd128, 8'd128, 1'b1, 16'd0, 16'd0, 1'b1},
      '{7'd60, 8'd255, 8'd128, 1'b0, 16'd0, 16'd0, 1'b0},
      '{7'd60, 8'd0, 8'd128, 1'b0, 16'd0, 16'd0, 1'b0},
      '{7'd60, 8'd128, 8'd0, 1'b0, 16'd0, 16'd0, 1'b0},
      '{7'd60, 8'd128, 8'd255, 1'b0, 16'd0, 16'd0, 1'b0},
      '{7'd60, 8'd0, 8'd0, 1'b0, 16'd0, 16'd0, 1'b0},
      '{7'd60, 8'd255, 8'd255, 1'b0, 16'd0, 16'd0, 1'b0},
      '{7'd60, 8'd0, 8'd255, 1'b0, 16'd0, 16'd0, 1'b0},
      '{7'd60, 8'd255, 8'd0, 1'b0, 16'd0, 16'd0, 1'b0},
      '{7'd60, 8'd187, 8'd128, 1'b1, 16'd0, 16'd0, 1'b1},
      '{7'd60, 8'd188, 8'd128, 1'b0, 16'd0, 16'd0, 1'b0},
      '{7'd60, 8'd128, 8'd69, 1'b1, 16'd0, 16'd0, 1'b1},
      '{7'd60, 8'd1, 8'd128, 1'b0, 16'd0, 16'd0, 1'b0},
      '{7'd0, 8'd128, 8'd128, 1'b1, 16'd0, 16'd0, 1'b0},
      '{7'd0, 8'd129, 8'd128, 1'b0, 16'd0, 16'd0, 1'b0},
      '{7'd0, 8'd127, 8'd128, 1'b0, 16'd0, 16'd0, 1'b0},
      '{7'd0, 8'd128, 8'd129, 1'b0, 16'd0, 16'd0, 1'b0},
      '{7'd127, 8'd255, 8'd128, 1'b0, 16'd0, 16'd0, 1'b0},
      '{7'd127, 8'd254, 8'd128, 1'b1, 16'd0, 16'd0, 1'b1},
      '{7'd127, 8'd0, 8'd0, 1'b0, 16'd0, 16'd0, 1'b0},
      '{7'd1, 8'd128, 8'd128, 1'b1, 16'd0, 16'd0, 1'b1},
      '{7'd1, 8'd129, 8'd129, 1'b0, 16'd0, 16'd0, 1'b0}
   };

   localparam logic [srdp_pkg::RADIUS_W-1:0] PHASE_RADIUS [5] =
      '{7'd0, 7'd127, 7'd1, 7'd126, 7'd60};
   localparam logic [7:0] EDGE_VALUES [7] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 100;
   localparam int SETTLE_CYCLES = 50;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [srdp_pkg::RADIUS_W-1:0] csr_wdata;

   srdp_req_if req_ch ();
   srdp_rsp_if rsp_ch ();

   logic [srdp_pkg::RADIUS_W-1:0] radius_now = srdp_pkg::RADIUS_RESET;
   srdp_pkg::rsp_type pending_polar[$];
   srdp_pkg::rsp_type expected_polar;
   int errors = 0;
   bit req_idle = 1'b1;
   bit rsp_calm = 1'b0;
   int unsigned rsp_stall;
   int unsigned rsp_draw;

   stick_radial_deadzone_polar #(
      .CORDIC_STAGES(STAGE_COUNT_CFG)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic srdp_pkg::rsp_type predict_polar(input logic [7:0] xr,
                                                       input logic [7:0] yr,
                                                       input logic [srdp_pkg::RADIUS_W-1:0] r);
      srdp_pkg::rsp_type res;
      longint x, y, d2, rr, v, root, bitv, base, mag, cx, cy, z, dx, dy, m, q, a;
      x = longint'(xr) - 128;
      y = 128 - longint'(yr);
      rr = longint'(r) * longint'(r);
      d2 = x * x + y * y;
      res = '0;
      if (d2 < rr) begin
         res.in_deadzone = 1'b1;
         return res;
      end
      v = d2 <<< 16;
      root = 0;
      bitv = longint'(1) <<< 62;
      while (bitv > v) bitv = bitv >>> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >>> 1) + bitv;
         end else begin
            root = root >>> 1;
         end
         bitv = bitv >>> 2;
      end
      base = longint'(r) * 256;
      mag = ((root >= base) ? root - base : 0) * 128 / (128 - longint'(r));
      if (mag > 32768) mag = 32768;
      res.magnitude = mag[15:0];
      if (x == 0 && y == 0) begin
         a = 0;
      end else begin
         cx = x * 65536;
         cy = y * 65536;
         z = 0;
         if (cx < 0) begin
            z = (cy >= 0) ? PI_ANGLE : -PI_ANGLE;
            cx = -cx;
            cy = -cy;
         end
         for (int i = 0; i < STAGE_COUNT_CFG && i < 24; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
               cx = cx + dx;
               cy = cy - dy;
               z = z + ATAN_Q30[i];
            end else begin
               cx = cx - dx;
               cy = cy + dy;
               z = z - ATAN_Q30[i];
            end
         end
         m = (z < 0) ? -z : z;
         q = (m + 65536) >>> 17;
         a = (z < 0) ? -q : q;
         if (a > 25736) a = 25736;
         if (a < -25736) a = -25736;
      end
      res.angle = a[15:0];
      return res;
   endfunction

   task automatic send_sample(input logic [7:0] xr, input logic [7:0] yr, input bit typed_in,
                              input srdp_pkg::rsp_type typed_rsp);
      int gap;
      gap = req_idle ? int'($urandom_range(0, 15)) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= '{x_raw: xr, y_raw: yr};
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_polar.push_back(typed_in ? typed_rsp : predict_polar(xr, yr, radius_now));
   endtask

   task automatic drain_pending();
      req_ch.valid <= 1'b0;
      while (pending_polar.size() != 0) @(posedge clock);
   endtask

   task automatic write_radius(input logic [srdp_pkg::RADIUS_W-1:0] r);
      csr_we <= 1'b1;
      csr_wdata <= r;
      @(posedge clock);
      csr_we <= 1'b0;
      radius_now = r;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         if (pending_polar.size() == 0) begin
            errors++;
            $display("%0t unexpected result: magnitude %0d angle %0d in_deadzone %0b", $time,
                     rsp_ch.data.magnitude, rsp_ch.data.angle, rsp_ch.data.in_deadzone);
         end else begin
            expected_polar = pending_polar.pop_front();
            if (rsp_ch.data.magnitude !== expected_polar.magnitude) begin
               errors++;
               $display("%0t magnitude mismatch: expected %0d, actual %0d", $time,
                        expected_polar.magnitude, rsp_ch.data.magnitude);
            end
            if (rsp_ch.data.angle !== expected_polar.angle) begin
               errors++;
               $display("%0t angle mismatch: expected %0d, actual %0d", $time,
                        expected_polar.angle, rsp_ch.data.angle);
            end
            if (rsp_ch.data.in_deadzone !== expected_polar.in_deadzone) begin
               errors++;
               $display("%0t in_deadzone mismatch: expected %0b, actual %0b", $time,
                        expected_polar.in_deadzone, rsp_ch.data.in_deadzone);
            end
         end
         if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
         rsp_draw = rsp_calm ? 0 : $urandom_range(0, 15);
         rsp_stall <= rsp_draw;
         rsp_ch.ready <= (rsp_draw == 0);
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ch.ready <= (rsp_stall == 1);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      int kind, span, ox, oy;
      logic [7:0] xr, yr;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (SAMPLE_ROWS[n]) begin
         if (SAMPLE_ROWS[n].radius != radius_now) begin
            drain_pending();
            write_radius(SAMPLE_ROWS[n].radius);
         end
         send_sample(SAMPLE_ROWS[n].x_raw, SAMPLE_ROWS[n].y_raw, SAMPLE_ROWS[n].typed_in,
                     '{magnitude: SAMPLE_ROWS[n].magnitude, angle: SAMPLE_ROWS[n].angle,
                       in_deadzone: SAMPLE_ROWS[n].in_deadzone});
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_pending();
         write_radius(phase < 5 ? PHASE_RADIUS[phase]
                                : srdp_pkg::RADIUS_W'($urandom_range(0, 127)));
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 25 == 0) req_idle = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            xr = 8'($urandom_range(0, 255));
            yr = 8'($urandom_range(0, 255));
            if (kind >= 6 && kind <= 7) begin
               // land near the deadzone edge
               span = int'(radius_now) + 2;
               ox = 128 + int'($urandom_range(0, 2 * span)) - span;
               oy = 128 + int'($urandom_range(0, 2 * span)) - span;
               if (ox < 0) ox = 0;
               if (ox > 255) ox = 255;
               if (oy < 0) oy = 0;
               if (oy > 255) oy = 255;
               xr = ox[7:0];
               yr = oy[7:0];
            end else if (kind == 8) begin
               xr = EDGE_VALUES[$urandom_range(0, 6)];
               yr = EDGE_VALUES[$urandom_range(0, 6)];
            end else if (kind == 9) begin
               if ($urandom_range(0, 1) == 0) xr = 8'd128;
               else yr = 8'd128;
            end
            send_sample(xr, yr, 1'b0, '0);
         end
      end

      drain_pending();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
